### rtl/jsu_pkg.sv
// Package: types, codes and helper functions of the JSON string unescape unit.
`timescale 1ns / 1ps

package jsu_pkg;

    // Decoder phase
    typedef enum logic [3:0] {
        PH_SEEK   = 4'd0,
        PH_STR    = 4'd1,
        PH_ESC    = 4'd2,
        PH_HEXHI  = 4'd3,
        PH_WANTBS = 4'd4,
        PH_WANTU  = 4'd5,
        PH_HEXLO  = 4'd6
    } t_phase;

    // Result kind
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // Error codes (ERR_NOQUOTE shares the all-zero code used when no error)
    typedef enum logic [2:0] {
        ERR_NOQUOTE = 3'd0,
        ERR_ESCCUT  = 3'd1,
        ERR_UNICODE = 3'd2,
        ERR_SURR    = 3'd3,
        ERR_UNSUPP  = 3'd4,
        ERR_UNTERM  = 3'd5
    } t_err;

    // Text characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Top six bits of high and low surrogates
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPPL_BASE   = 21'h10000;

    localparam int RES_MAX = 4;
    localparam int RES_IW  = $clog2(RES_MAX);

    // One group of results caused by one input transaction
    typedef struct packed {
        logic                          nonempty;
        logic [RES_IW-1:0]             last_idx;
        t_kind                         kind;
        t_err                          err;
        logic [RES_MAX-1:0][7:0]       bytes;
    } t_grp;

    typedef struct packed {
        logic [RES_IW-1:0]             last_idx;
        logic [RES_MAX-1:0][7:0]       bytes;
    } t_utf8;

    // Hex digit value, bit 4 set for a non-hex byte
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    // White space: space, tab, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // UTF-8 encoding of one code point, first byte in slot 0
    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 u;
        u.bytes = '0;
        if (cp <= 21'h7F) begin
            u.last_idx = RES_IW'(0);
            u.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            u.last_idx = RES_IW'(1);
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            u.last_idx = RES_IW'(2);
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.last_idx = RES_IW'(3);
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

### rtl/json_string_unescape_unit.sv
// Top level of the JSON string unescape unit: decoder plus result register.
//
//  Channel  Dir  tdata            tuser                      tlast
//  s_axis   in   text byte [7:0]  text end [0]               -
//  m_axis   out  out byte [7:0]   kind [1:0], error [4:2]    final result of the byte
//
//  One input transaction per cycle when it causes at most one result and m_axis does not stall.
//  A byte that gives k results (k up to 4, a UTF-8 sequence) holds
//  s_axis_tready low while the result register drains.
//  The first result of a byte appears in the cycle after the byte is taken, from the result register.
//  Synchronous active-low reset returns the decoder to seeking a quote
//  and empties the result register; stalls on m_axis back up into s_axis.
`timescale 1ns / 1ps

module json_string_unescape_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_axis_tuser,   // [0] text_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [4:0]  m_axis_tuser,   // [1:0] out_kind, [4:2] error_code
    output logic        m_axis_tlast    // last
);

    jsu_pkg::t_grp w_grp;
    logic          w_accept;
    logic [1:0]    w_kind;
    logic [2:0]    w_err;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_end    (s_axis_tuser[0]),
        .o_grp    (w_grp)
    );

    jsu_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_grp    (w_grp),
        .o_ready  (s_axis_tready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (m_axis_tdata),
        .o_kind   (w_kind),
        .o_err    (w_err),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tuser = {w_err, w_kind};

endmodule

### rtl/jsu_decode.sv
// Decoder: phase state machine, hex accumulator and UTF-8 result group build.
`timescale 1ns / 1ps

module jsu_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_end,
    output jsu_pkg::t_grp   o_grp
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_hex_left, n_hex_left;
    logic [15:0]     r_code, n_code;
    logic [9:0]      r_high, n_high;

    logic [4:0]      w_digit;
    logic            w_bad_digit;
    logic [15:0]     w_code;
    logic            w_is_high;
    logic            w_is_low;
    logic [20:0]     w_pair_cp;
    jsu_pkg::t_utf8  w_bmp_enc;
    jsu_pkg::t_utf8  w_pair_enc;

    // Digit decode and shifted accumulator
    assign w_digit     = i_end ? 5'h10 : jsu_pkg::hex_value(i_byte);
    assign w_bad_digit = w_digit[4];
    assign w_code      = {r_code[11:0], w_digit[3:0]};
    assign w_is_high   = (w_code[15:10] == jsu_pkg::SURR_HIGH_TAG);
    assign w_is_low    = (w_code[15:10] == jsu_pkg::SURR_LOW_TAG);
    assign w_pair_cp   = jsu_pkg::SUPPL_BASE + {1'b0, r_high, w_code[9:0]};
    assign w_bmp_enc   = jsu_pkg::utf8_encode({5'd0, w_code});
    assign w_pair_enc  = jsu_pkg::utf8_encode(w_pair_cp);

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_hex_left = r_hex_left;
        n_code     = r_code;
        n_high     = r_high;
        if (i_accept) begin
            case (r_phase)
                jsu_pkg::PH_STR: begin
                    if (i_end || i_byte == jsu_pkg::CH_QUOTE) begin
                        n_phase = jsu_pkg::PH_SEEK;
                    end else if (i_byte == jsu_pkg::CH_BSLASH) begin
                        n_phase = jsu_pkg::PH_ESC;
                    end
                end
                jsu_pkg::PH_ESC: begin
                    if (i_end) begin
                        n_phase = jsu_pkg::PH_SEEK;
                    end else begin
                        case (i_byte)
                            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                            jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                            jsu_pkg::CH_R, jsu_pkg::CH_T: begin
                                n_phase = jsu_pkg::PH_STR;
                            end
                            jsu_pkg::CH_U: begin
                                n_phase    = jsu_pkg::PH_HEXHI;
                                n_hex_left = 2'd3;
                                n_code     = '0;
                            end
                            default: begin
                                n_phase = jsu_pkg::PH_SEEK;
                            end
                        endcase
                    end
                end
                jsu_pkg::PH_HEXHI, jsu_pkg::PH_HEXLO: begin
                    if (w_bad_digit) begin
                        n_phase = jsu_pkg::PH_SEEK;
                    end else begin
                        n_code = w_code;
                        if (r_hex_left != 2'd0) begin
                            n_hex_left = r_hex_left - 2'd1;
                        end else if (r_phase == jsu_pkg::PH_HEXHI) begin
                            if (w_is_high) begin
                                n_high  = w_code[9:0];
                                n_phase = jsu_pkg::PH_WANTBS;
                            end else if (w_is_low) begin
                                n_phase = jsu_pkg::PH_SEEK;
                            end else begin
                                n_phase = jsu_pkg::PH_STR;
                            end
                        end else begin
                            n_phase = w_is_low ? jsu_pkg::PH_STR : jsu_pkg::PH_SEEK;
                        end
                    end
                end
                jsu_pkg::PH_WANTBS: begin
                    n_phase = (!i_end && i_byte == jsu_pkg::CH_BSLASH) ?
                              jsu_pkg::PH_WANTU : jsu_pkg::PH_SEEK;
                end
                jsu_pkg::PH_WANTU: begin
                    if (!i_end && i_byte == jsu_pkg::CH_U) begin
                        n_phase    = jsu_pkg::PH_HEXLO;
                        n_hex_left = 2'd3;
                        n_code     = '0;
                    end else begin
                        n_phase = jsu_pkg::PH_SEEK;
                    end
                end
                // seeking the opening quote, also any unused code
                default: begin
                    n_phase = (!i_end && i_byte == jsu_pkg::CH_QUOTE) ?
                              jsu_pkg::PH_STR : jsu_pkg::PH_SEEK;
                end
            endcase
        end
    end

    // Result group for the current transaction
    always_comb begin
        o_grp          = '0;
        o_grp.kind     = jsu_pkg::KIND_BYTE;
        o_grp.err      = jsu_pkg::ERR_NOQUOTE;
        case (r_phase)
            jsu_pkg::PH_STR: begin
                o_grp.nonempty = !(!i_end && i_byte == jsu_pkg::CH_BSLASH);
                if (i_end) begin
                    o_grp.kind = jsu_pkg::KIND_ERROR;
                    o_grp.err  = jsu_pkg::ERR_UNTERM;
                end else if (i_byte == jsu_pkg::CH_QUOTE) begin
                    o_grp.kind = jsu_pkg::KIND_DONE;
                end else begin
                    o_grp.bytes[0] = i_byte;
                end
            end
            jsu_pkg::PH_ESC: begin
                o_grp.nonempty = 1'b1;
                if (i_end) begin
                    o_grp.kind = jsu_pkg::KIND_ERROR;
                    o_grp.err  = jsu_pkg::ERR_ESCCUT;
                end else begin
                    case (i_byte)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
                            o_grp.bytes[0] = i_byte;
                        end
                        jsu_pkg::CH_B: o_grp.bytes[0] = 8'h08;
                        jsu_pkg::CH_F: o_grp.bytes[0] = 8'h0C;
                        jsu_pkg::CH_N: o_grp.bytes[0] = 8'h0A;
                        jsu_pkg::CH_R: o_grp.bytes[0] = 8'h0D;
                        jsu_pkg::CH_T: o_grp.bytes[0] = 8'h09;
                        jsu_pkg::CH_U: o_grp.nonempty = 1'b0;
                        default: begin
                            o_grp.kind = jsu_pkg::KIND_ERROR;
                            o_grp.err  = jsu_pkg::ERR_UNSUPP;
                        end
                    endcase
                end
            end
            jsu_pkg::PH_HEXHI, jsu_pkg::PH_HEXLO: begin
                if (w_bad_digit) begin
                    o_grp.nonempty = 1'b1;
                    o_grp.kind     = jsu_pkg::KIND_ERROR;
                    o_grp.err      = jsu_pkg::ERR_UNICODE;
                end else if (r_hex_left == 2'd0) begin
                    if (r_phase == jsu_pkg::PH_HEXHI) begin
                        if (w_is_low) begin
                            o_grp.nonempty = 1'b1;
                            o_grp.kind     = jsu_pkg::KIND_ERROR;
                            o_grp.err      = jsu_pkg::ERR_SURR;
                        end else if (!w_is_high) begin
                            o_grp.nonempty = 1'b1;
                            o_grp.last_idx = w_bmp_enc.last_idx;
                            o_grp.bytes    = w_bmp_enc.bytes;
                        end
                    end else begin
                        o_grp.nonempty = 1'b1;
                        if (w_is_low) begin
                            o_grp.last_idx = w_pair_enc.last_idx;
                            o_grp.bytes    = w_pair_enc.bytes;
                        end else begin
                            o_grp.kind = jsu_pkg::KIND_ERROR;
                            o_grp.err  = jsu_pkg::ERR_SURR;
                        end
                    end
                end
            end
            jsu_pkg::PH_WANTBS: begin
                if (i_end || i_byte != jsu_pkg::CH_BSLASH) begin
                    o_grp.nonempty = 1'b1;
                    o_grp.kind     = jsu_pkg::KIND_ERROR;
                    o_grp.err      = jsu_pkg::ERR_SURR;
                end
            end
            jsu_pkg::PH_WANTU: begin
                if (i_end || i_byte != jsu_pkg::CH_U) begin
                    o_grp.nonempty = 1'b1;
                    o_grp.kind     = jsu_pkg::KIND_ERROR;
                    o_grp.err      = jsu_pkg::ERR_SURR;
                end
            end
            // seeking: anything but white space or a quote is an error
            default: begin
                if (i_end || (i_byte != jsu_pkg::CH_QUOTE && !jsu_pkg::is_space(i_byte)))
                begin
                    o_grp.nonempty = 1'b1;
                    o_grp.kind     = jsu_pkg::KIND_ERROR;
                    o_grp.err      = jsu_pkg::ERR_NOQUOTE;
                end
            end
        endcase
        if (!i_accept) begin
            o_grp.nonempty = 1'b0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= jsu_pkg::PH_SEEK;
            r_hex_left <= '0;
            r_code     <= '0;
            r_high     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_hex_left <= n_hex_left;
            r_code     <= n_code;
            r_high     <= n_high;
        end
    end

endmodule

### rtl/jsu_emit.sv
// Result register: holds one result group and hands it out one transaction a cycle while i_ready is high.
`timescale 1ns / 1ps

module jsu_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jsu_pkg::t_grp   i_grp,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic [1:0]      o_kind,
    output logic [2:0]      o_err,
    output logic            o_last
);

    logic                          r_valid, n_valid;
    logic [jsu_pkg::RES_IW-1:0]    r_idx, n_idx;
    jsu_pkg::t_grp                 r_grp, n_grp;
    logic                          w_pop;
    logic                          w_at_last;

    assign w_pop     = r_valid && i_ready;
    assign w_at_last = (r_idx == r_grp.last_idx);
    // free for a new group when empty or once the final result of this one leaves
    assign o_ready   = !r_valid || (w_pop && w_at_last);

    // Next group and read index
    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        n_grp   = r_grp;
        if (o_ready && i_grp.nonempty) begin
            n_valid = 1'b1;
            n_idx   = '0;
            n_grp   = i_grp;
        end else if (w_pop && w_at_last) begin
            n_valid = 1'b0;
        end else if (w_pop) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    assign o_valid = r_valid;
    assign o_byte  = r_grp.bytes[r_idx];
    assign o_kind  = r_grp.kind;
    assign o_err   = r_grp.err;
    assign o_last  = w_at_last;

endmodule

### rtl/jsu_checker.sv
// Port-level checker for the JSON string unescape unit, bound to the top level.
`timescale 1ns / 1ps

module jsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [4:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic w_byte_kind;
    assign w_byte_kind = (m_axis_tuser[1:0] == jsu_pkg::KIND_BYTE);

    // A close or an error is always the only result of its byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_byte_kind |-> m_axis_tlast)
        else $error("close or error result without tlast");

    // Status results carry a zero byte
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_byte_kind |-> m_axis_tdata == 8'h00)
        else $error("close or error result with nonzero byte");

    // Decoded bytes carry no error code
    a_byte_noerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_byte_kind |-> m_axis_tuser[4:2] == 3'd0)
        else $error("decoded byte with error code");

    // Input held off while a multi-byte group is still draining
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken during an unfinished result group");

    // The rest of a group follows right after a taken non-final result
    a_group_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("result group broken off");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
